FILE: rtl/core/gamepad_radial_deadzone_defines.svh
// Assertion macros for the radial dead-zone block
`ifndef GAMEPAD_RADIAL_DEADZONE_DEFINES_SVH
`define GAMEPAD_RADIAL_DEADZONE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GPRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gprd assertion failed");
`define GPRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gprd assertion failed");
`else
`define GPRD_ASSERT_IMP(lbl, ante, cons)
`define GPRD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/gprd_pkg.sv
// Shared constants for the radial dead-zone pipeline
`default_nettype none

package gprd_pkg;

  localparam int IN_BITS        = 80;
  localparam int OUT_BITS       = 128;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [CFG_ADDR_BITS-1:0] REG_LEFT_DZ  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RIGHT_DZ = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TRIG_THR = 2'd2;

  localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
  localparam logic [7:0]  TRIG_THR_RESET = 8'd30;

  localparam logic [14:0] STICK_FULL = 15'd32767;
  localparam logic [7:0]  TRIG_FULL  = 8'd255;
  localparam int          ONE_Q15    = 32768;

  localparam int SQRT_STEPS     = 31;
  localparam int M2_PAIRS       = 16;
  localparam int DIV_STEPS      = 18;
  localparam int TRIG_DIV_STEPS = 16;
  localparam int PIPE_DEPTH     = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int TRIG_DELAY     = PIPE_DEPTH - TRIG_DIV_STEPS - 1;

endpackage

`default_nettype wire

FILE: rtl/core/gprd_stick.sv
// One stick lane: squares, digit-serial square root, three restoring dividers
`default_nettype none

module gprd_stick
  import gprd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] x,
  input  logic [15:0] y,
  input  logic [14:0] dead_zone,
  output logic [15:0] dir_x,
  output logic [15:0] dir_y,
  output logic [15:0] level
);

  function automatic logic [15:0] dir_fmt(input logic [17:0] qraw, input logic neg,
                                          input logic zero);
    logic [18:0] rnd;
    logic [17:0] q;
    logic [15:0] mag;
    rnd = {1'b0, qraw} + 19'd1;
    q   = rnd[18:1];
    if (q > 18'(ONE_Q15)) q = 18'(ONE_Q15);
    mag = q[15:0];
    if (zero) begin
      dir_fmt = 16'd0;
    end else if (neg) begin
      dir_fmt = (~mag) + 16'd1;
    end else if (q >= 18'(ONE_Q15)) begin
      dir_fmt = {1'b0, STICK_FULL};
    end else begin
      dir_fmt = mag;
    end
  endfunction

  logic [16:0] ax_in, ay_in;
  logic        sy_in;
  logic [29:0] dz_sq;

  logic [16:0] s0_ax, s0_ay;
  logic        s0_sx, s0_sy;
  logic [30:0] s0_xx, s0_yy;

  logic [31:0] s1_m2;
  logic [16:0] s1_ax, s1_ay;
  logic        s1_sx, s1_sy;

  logic [31:0] sq_rem     [SQRT_STEPS];
  logic [30:0] sq_root    [SQRT_STEPS];
  logic [31:0] sq_m2      [SQRT_STEPS];
  logic [16:0] sq_ax      [SQRT_STEPS];
  logic [16:0] sq_ay      [SQRT_STEPS];
  logic        sq_sx      [SQRT_STEPS];
  logic        sq_sy      [SQRT_STEPS];
  logic        sq_gt      [SQRT_STEPS];
  logic [31:0] sq_in_rem  [SQRT_STEPS];
  logic [30:0] sq_in_root [SQRT_STEPS];
  logic [31:0] sq_in_m2   [SQRT_STEPS];
  logic [1:0]  sq_bits    [SQRT_STEPS];
  logic [34:0] sq_trial   [SQRT_STEPS];
  logic [31:0] sq_rem_next  [SQRT_STEPS];
  logic [30:0] sq_root_next [SQRT_STEPS];

  logic [15:0] r_int;
  logic [14:0] r_clip, l_den;
  logic [29:0] l_num;
  logic        l_ok;

  logic [30:0] pr_s, pr_xr, pr_yr;
  logic [29:0] pr_lnum;
  logic [14:0] pr_lden;
  logic        pr_sx, pr_sy, pr_z;

  logic [30:0] dv_xr [DIV_STEPS];
  logic [30:0] dv_yr [DIV_STEPS];
  logic [17:0] dv_xq [DIV_STEPS];
  logic [17:0] dv_yq [DIV_STEPS];
  logic [14:0] dv_lr [DIV_STEPS];
  logic [17:0] dv_lq [DIV_STEPS];
  logic [30:0] dv_s  [DIV_STEPS];
  logic [14:0] dv_lden [DIV_STEPS];
  logic [17:0] dv_lo [DIV_STEPS];
  logic        dv_sx [DIV_STEPS];
  logic        dv_sy [DIV_STEPS];
  logic        dv_z  [DIV_STEPS];

  logic [30:0] dv_in_xr [DIV_STEPS];
  logic [30:0] dv_in_yr [DIV_STEPS];
  logic [17:0] dv_in_xq [DIV_STEPS];
  logic [17:0] dv_in_yq [DIV_STEPS];
  logic [14:0] dv_in_lr [DIV_STEPS];
  logic [17:0] dv_in_lq [DIV_STEPS];
  logic [30:0] dv_in_s  [DIV_STEPS];
  logic [14:0] dv_in_lden [DIV_STEPS];
  logic [17:0] dv_in_lo [DIV_STEPS];
  logic        dv_lbit  [DIV_STEPS];
  logic [32:0] dv_xt    [DIV_STEPS];
  logic [32:0] dv_yt    [DIV_STEPS];
  logic [16:0] dv_lt    [DIV_STEPS];
  logic [30:0] dv_xr_next [DIV_STEPS];
  logic [30:0] dv_yr_next [DIV_STEPS];
  logic [14:0] dv_lr_next [DIV_STEPS];

  // magnitudes and signs of x and of -y
  assign ax_in = x[15] ? 17'(-{1'b1, x}) : {1'b0, x};
  assign ay_in = y[15] ? 17'(-{1'b1, y}) : {1'b0, y};
  assign sy_in = !y[15] && (y != 16'd0);

  always_ff @(posedge clk) begin
    dz_sq <= 30'({15'd0, dead_zone} * {15'd0, dead_zone});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax <= ax_in;
      s0_ay <= ay_in;
      s0_sx <= x[15];
      s0_sy <= sy_in;
      s0_xx <= 31'({14'd0, ax_in} * {14'd0, ax_in});
      s0_yy <= 31'({14'd0, ay_in} * {14'd0, ay_in});
      s1_m2 <= {1'b0, s0_xx} + {1'b0, s0_yy};
      s1_ax <= s0_ax;
      s1_ay <= s0_ay;
      s1_sx <= s0_sx;
      s1_sy <= s0_sy;
    end
  end

  // square root of m2 * 2^30, one result bit per stage
  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        sq_in_rem[k]  = '0;
        sq_in_root[k] = '0;
        sq_in_m2[k]   = s1_m2;
      end else begin
        sq_in_rem[k]  = sq_rem[k-1];
        sq_in_root[k] = sq_root[k-1];
        sq_in_m2[k]   = sq_m2[k-1];
      end
      if (k < M2_PAIRS) begin
        sq_bits[k] = 2'(sq_in_m2[k] >> (2 * (M2_PAIRS - 1 - k)));
      end else begin
        sq_bits[k] = 2'b00;
      end
      sq_trial[k] = {1'b0, sq_in_rem[k], sq_bits[k]} - {2'b00, sq_in_root[k], 2'b01};
      if (!sq_trial[k][34]) begin
        sq_rem_next[k]  = sq_trial[k][31:0];
        sq_root_next[k] = {sq_in_root[k][29:0], 1'b1};
      end else begin
        sq_rem_next[k]  = {sq_in_rem[k][29:0], sq_bits[k]};
        sq_root_next[k] = {sq_in_root[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_rem[k]  <= sq_rem_next[k];
        sq_root[k] <= sq_root_next[k];
        sq_m2[k]   <= sq_in_m2[k];
        if (k == 0) begin
          sq_ax[k] <= s1_ax;
          sq_ay[k] <= s1_ay;
          sq_sx[k] <= s1_sx;
          sq_sy[k] <= s1_sy;
          sq_gt[k] <= s1_m2 > {2'b00, dz_sq};
        end else begin
          sq_ax[k] <= sq_ax[k-1];
          sq_ay[k] <= sq_ay[k-1];
          sq_sx[k] <= sq_sx[k-1];
          sq_sy[k] <= sq_sy[k-1];
          sq_gt[k] <= sq_gt[k-1];
        end
      end
    end
  end

  // integer root is the top of the scaled root
  assign r_int  = sq_root[SQRT_STEPS-1][30:15];
  assign r_clip = r_int[15] ? STICK_FULL : r_int[14:0];
  assign l_den  = STICK_FULL - dead_zone;
  assign l_num  = {15'(r_clip - dead_zone), 15'd0} + {16'd0, l_den[14:1]};
  assign l_ok   = sq_gt[SQRT_STEPS-1] && (l_den != 15'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      pr_s    <= sq_root[SQRT_STEPS-1];
      pr_z    <= sq_root[SQRT_STEPS-1] == 31'd0;
      pr_xr   <= {1'b0, sq_ax[SQRT_STEPS-1], 13'd0};
      pr_yr   <= {1'b0, sq_ay[SQRT_STEPS-1], 13'd0};
      pr_sx   <= sq_sx[SQRT_STEPS-1];
      pr_sy   <= sq_sy[SQRT_STEPS-1];
      pr_lnum <= l_ok ? l_num : 30'd0;
      pr_lden <= l_ok ? l_den : 15'd1;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        dv_in_xr[j]   = pr_xr;
        dv_in_yr[j]   = pr_yr;
        dv_in_xq[j]   = '0;
        dv_in_yq[j]   = '0;
        dv_in_lr[j]   = {3'd0, pr_lnum[29:18]};
        dv_in_lq[j]   = '0;
        dv_in_s[j]    = pr_s;
        dv_in_lden[j] = pr_lden;
        dv_in_lo[j]   = pr_lnum[17:0];
      end else begin
        dv_in_xr[j]   = dv_xr[j-1];
        dv_in_yr[j]   = dv_yr[j-1];
        dv_in_xq[j]   = dv_xq[j-1];
        dv_in_yq[j]   = dv_yq[j-1];
        dv_in_lr[j]   = dv_lr[j-1];
        dv_in_lq[j]   = dv_lq[j-1];
        dv_in_s[j]    = dv_s[j-1];
        dv_in_lden[j] = dv_lden[j-1];
        dv_in_lo[j]   = dv_lo[j-1];
      end
      dv_lbit[j] = dv_in_lo[j][DIV_STEPS-1-j];
      dv_xt[j] = {1'b0, dv_in_xr[j], 1'b0} - {2'b00, dv_in_s[j]};
      dv_yt[j] = {1'b0, dv_in_yr[j], 1'b0} - {2'b00, dv_in_s[j]};
      dv_lt[j] = {1'b0, dv_in_lr[j], dv_lbit[j]} - {2'b00, dv_in_lden[j]};
      dv_xr_next[j] = dv_xt[j][32] ? {dv_in_xr[j][29:0], 1'b0} : dv_xt[j][30:0];
      dv_yr_next[j] = dv_yt[j][32] ? {dv_in_yr[j][29:0], 1'b0} : dv_yt[j][30:0];
      dv_lr_next[j] = dv_lt[j][16] ? {dv_in_lr[j][13:0], dv_lbit[j]} : dv_lt[j][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_xr[j]   <= dv_xr_next[j];
        dv_yr[j]   <= dv_yr_next[j];
        dv_lr[j]   <= dv_lr_next[j];
        dv_xq[j]   <= {dv_in_xq[j][16:0], !dv_xt[j][32]};
        dv_yq[j]   <= {dv_in_yq[j][16:0], !dv_yt[j][32]};
        dv_lq[j]   <= {dv_in_lq[j][16:0], !dv_lt[j][16]};
        dv_s[j]    <= dv_in_s[j];
        dv_lden[j] <= dv_in_lden[j];
        dv_lo[j]   <= dv_in_lo[j];
        if (j == 0) begin
          dv_sx[j] <= pr_sx;
          dv_sy[j] <= pr_sy;
          dv_z[j]  <= pr_z;
        end else begin
          dv_sx[j] <= dv_sx[j-1];
          dv_sy[j] <= dv_sy[j-1];
          dv_z[j]  <= dv_z[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x <= dir_fmt(dv_xq[DIV_STEPS-1], dv_sx[DIV_STEPS-1], dv_z[DIV_STEPS-1]);
      dir_y <= dir_fmt(dv_yq[DIV_STEPS-1], dv_sy[DIV_STEPS-1], dv_z[DIV_STEPS-1]);
      level <= dv_lq[DIV_STEPS-1][15:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gamepad_radial_deadzone.sv
// Throughput: one beat per cycle; the whole pipeline stalls while a result is held.
// Each stick runs a 31-stage square root and 18-stage restoring dividers.
// rst clears the valid chain and loads the default dead zones and threshold.
`default_nettype none

`include "gamepad_radial_deadzone_defines.svh"

module gamepad_radial_deadzone
  import gprd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // left_x, left_y, right_x, right_y, left_trig, right_trig
  input  logic [IN_BITS-1:0]       s_tdata,
  // connected
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // left_dir_x, left_dir_y, left_level, right_dir_x, right_dir_y, right_level,
  // left_trig_level, right_trig_level
  output logic [OUT_BITS-1:0]      m_tdata,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [14:0] left_dz, right_dz;
  logic [7:0]  trig_thr;
  logic        en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] cn;

  logic [15:0] l_dx, l_dy, l_lev, r_dx, r_dy, r_lev;

  logic [7:0]  td     [2][TRIG_DELAY];
  logic [7:0]  tg_t   [2];
  logic        tg_ok  [2];
  logic [7:0]  tg_den;
  logic [22:0] tp_num [2];
  logic [7:0]  tp_den [2];

  logic [7:0]  tv_r   [2][TRIG_DIV_STEPS];
  logic [15:0] tv_q   [2][TRIG_DIV_STEPS];
  logic [7:0]  tv_den [2][TRIG_DIV_STEPS];
  logic [15:0] tv_lo  [2][TRIG_DIV_STEPS];
  logic [7:0]  tv_in_r   [2][TRIG_DIV_STEPS];
  logic [15:0] tv_in_q   [2][TRIG_DIV_STEPS];
  logic [7:0]  tv_in_den [2][TRIG_DIV_STEPS];
  logic [15:0] tv_in_lo  [2][TRIG_DIV_STEPS];
  logic        tv_bit    [2][TRIG_DIV_STEPS];
  logic [9:0]  tv_t      [2][TRIG_DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RESET;
      right_dz <= RIGHT_DZ_RESET;
      trig_thr <= TRIG_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEFT_DZ:  left_dz  <= cfg_data;
        REG_RIGHT_DZ: right_dz <= cfg_data;
        REG_TRIG_THR: trig_thr <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cn <= {cn[PIPE_DEPTH-2:0], s_tuser};
    end
  end

  gprd_stick u_left (
    .clk       (clk),
    .en        (en),
    .x         (s_tdata[15:0]),
    .y         (s_tdata[31:16]),
    .dead_zone (left_dz),
    .dir_x     (l_dx),
    .dir_y     (l_dy),
    .level     (l_lev)
  );

  gprd_stick u_right (
    .clk       (clk),
    .en        (en),
    .x         (s_tdata[47:32]),
    .y         (s_tdata[63:48]),
    .dead_zone (right_dz),
    .dir_x     (r_dx),
    .dir_y     (r_dy),
    .level     (r_lev)
  );

  // triggers wait in a delay line, then a short divider lines them up with the sticks
  always_ff @(posedge clk) begin
    if (en) begin
      td[0][0] <= s_tdata[71:64];
      td[1][0] <= s_tdata[79:72];
      for (int k = 1; k < TRIG_DELAY; k++) begin
        td[0][k] <= td[0][k-1];
        td[1][k] <= td[1][k-1];
      end
    end
  end

  assign tg_den = TRIG_FULL - trig_thr;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tg_t[i]  = td[i][TRIG_DELAY-1];
      tg_ok[i] = (tg_t[i] > trig_thr) && (tg_den != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        tp_num[i] <= tg_ok[i] ? ({8'(tg_t[i] - trig_thr), 15'd0} + {16'd0, tg_den[7:1]})
                              : 23'd0;
        tp_den[i] <= tg_ok[i] ? tg_den : 8'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < TRIG_DIV_STEPS; j++) begin
        if (j == 0) begin
          tv_in_r[i][j]   = {1'b0, tp_num[i][22:16]};
          tv_in_q[i][j]   = '0;
          tv_in_den[i][j] = tp_den[i];
          tv_in_lo[i][j]  = tp_num[i][15:0];
        end else begin
          tv_in_r[i][j]   = tv_r[i][j-1];
          tv_in_q[i][j]   = tv_q[i][j-1];
          tv_in_den[i][j] = tv_den[i][j-1];
          tv_in_lo[i][j]  = tv_lo[i][j-1];
        end
        tv_bit[i][j] = tv_in_lo[i][j][TRIG_DIV_STEPS-1-j];
        tv_t[i][j]   = {1'b0, tv_in_r[i][j], tv_bit[i][j]} - {2'b00, tv_in_den[i][j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < TRIG_DIV_STEPS; j++) begin
          tv_r[i][j]   <= tv_t[i][j][9] ? {tv_in_r[i][j][6:0], tv_bit[i][j]}
                                        : tv_t[i][j][7:0];
          tv_q[i][j]   <= {tv_in_q[i][j][14:0], !tv_t[i][j][9]};
          tv_den[i][j] <= tv_in_den[i][j];
          tv_lo[i][j]  <= tv_in_lo[i][j];
        end
      end
    end
  end

  assign m_tdata = cn[PIPE_DEPTH-1]
                 ? {tv_q[1][TRIG_DIV_STEPS-1], tv_q[0][TRIG_DIV_STEPS-1],
                    r_lev, r_dy, r_dx, l_lev, l_dy, l_dx}
                 : '0;

  `GPRD_ASSERT_NXT(a_enter_pipe, s_tvalid && s_tready, vld[0])
  `GPRD_ASSERT_NXT(a_stall_holds, vld[0] && !en, vld[0])
  `GPRD_ASSERT_IMP(a_left_level, m_tvalid, m_tdata[47:32] <= 16'd32768)
  `GPRD_ASSERT_IMP(a_right_level, m_tvalid, m_tdata[95:80] <= 16'd32768)
  `GPRD_ASSERT_IMP(a_left_trig, m_tvalid, m_tdata[111:96] <= 16'd32768)
  `GPRD_ASSERT_IMP(a_right_trig, m_tvalid, m_tdata[127:112] <= 16'd32768)

endmodule

`default_nettype wire

FILE: tb/sv/gamepad_radial_deadzone_tb.sv
// Testbench for the gamepad radial dead-zone block: streamed samples against a built-in predictor
module gamepad_radial_deadzone_tb
  import gprd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  class stick_board;
    logic [14:0] left_dz, right_dz;
    logic [7:0]  trig_thr;
    logic [OUT_BITS-1:0] pending[$];
    int errors;
    int n_in;

    function new();
      left_dz  = LEFT_DZ_RESET;
      right_dz = RIGHT_DZ_RESET;
      trig_thr = TRIG_THR_RESET;
      errors   = 0;
      n_in     = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_LEFT_DZ:  left_dz  = val;
        REG_RIGHT_DZ: right_dz = val;
        REG_TRIG_THR: trig_thr = val[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [15:0] unit_comp(longint n, longint unsigned s);
      longint unsigned a, q;
      if (s == 0) return 16'd0;
      a = (n < 0) ? -n : n;
      q = (((a << 31) / s) + 1) >> 1;
      if (q > 32768) q = 32768;
      if (n >= 0) begin
        if (q > 32767) q = 32767;
        return q[15:0];
      end
      return 16'(65536 - q);
    endfunction

    // {level, dir_y, dir_x}
    function logic [47:0] stick_out(logic signed [15:0] rx, logic signed [15:0] ry,
                                    logic [14:0] dz);
      longint x, y;
      longint unsigned m2, s, r, den, lvl, d;
      x = rx;
      y = ry;
      d = dz;
      m2 = x * x + y * y;
      s = int_sqrt(m2 << 30);
      lvl = 0;
      if (m2 > d * d) begin
        r = int_sqrt(m2);
        den = 32767 - d;
        if (r > 32767) r = 32767;
        if (den != 0) lvl = ((r - d) * 32768 + den / 2) / den;
      end
      return {lvl[15:0], unit_comp(-y, s), unit_comp(x, s)};
    endfunction

    function logic [15:0] trig_out(logic [7:0] t);
      longint unsigned den, lvl;
      if (t <= trig_thr) return 16'd0;
      den = 255 - trig_thr;
      if (den == 0) return 16'd0;
      lvl = ((t - trig_thr) * 32768 + den / 2) / den;
      return lvl[15:0];
    endfunction

    function void note_sample(logic [IN_BITS-1:0] d, logic conn);
      logic [OUT_BITS-1:0] e;
      e = '0;
      if (conn) begin
        e[47:0]    = stick_out(d[15:0], d[31:16], left_dz);
        e[95:48]   = stick_out(d[47:32], d[63:48], right_dz);
        e[111:96]  = trig_out(d[71:64]);
        e[127:112] = trig_out(d[79:72]);
      end
      pending.push_back(e);
      n_in++;
    endfunction

    function void check_result(logic [OUT_BITS-1:0] got);
      string names[8] = '{"left_dir_x", "left_dir_y", "left_level", "right_dir_x",
                          "right_dir_y", "right_level", "left_trig_level",
                          "right_trig_level"};
      logic [OUT_BITS-1:0] e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 8; i++)
        if (got[16*i +: 16] !== e[16*i +: 16]) begin
          $error("%s expected %h got %h", names[i], e[16*i +: 16], got[16*i +: 16]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BITS-1:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  stick_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  bit held = 0;

  gamepad_radial_deadzone dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (!held && board.n_in >= 1000) begin
      held = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);

  task automatic send_sample(logic signed [15:0] lx, logic signed [15:0] ly,
                             logic signed [15:0] rx, logic signed [15:0] ry,
                             logic [7:0] lt, logic [7:0] rt, logic conn);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {rt, lt, ry, rx, ly, lx};
    s_tuser  <= conn;
    do @(posedge clk); while (!s_tready);
    board.note_sample({rt, lt, ry, rx, ly, lx}, conn);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we   <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_axis(int dz);
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(2 * dz + 2)) - dz - 1);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_samples(int n);
    for (int i = 0; i < n; i++)
      send_sample(rand_axis(int'(board.left_dz)), rand_axis(int'(board.left_dz)),
                  rand_axis(int'(board.right_dz)), rand_axis(int'(board.right_dz)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  $urandom_range(9) != 0);
  endtask

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: centre, extremes, dead-zone edges, trigger edges, disconnected
    send_sample(0, 0, 0, 0, 0, 0, 1);
    send_sample(-32768, -32768, -32768, -32768, 255, 255, 1);
    send_sample(32767, 32767, 32767, 32767, 30, 31, 1);
    send_sample(-32768, 0, 0, -32768, 31, 30, 1);
    send_sample(32767, 0, 0, 32767, 254, 1, 1);
    send_sample(7849, 0, 8689, 0, 0, 255, 1);
    send_sample(7850, 0, 8690, 0, 29, 32, 1);
    send_sample(0, -7849, 0, 8689, 100, 200, 1);
    send_sample(5550, 5550, -6144, 6144, 128, 64, 1);
    send_sample(1, -1, -1, 1, 255, 0, 1);
    send_sample(-32768, -32768, 32767, 32767, 255, 255, 0);
    send_sample(1234, -4321, 20000, -20000, 77, 88, 0);
    send_sample(-1, 0, 0, 1, 31, 255, 1);
    drain();
    write_reg(REG_LEFT_DZ, 15'd0);
    write_reg(REG_RIGHT_DZ, 15'd32767);
    write_reg(REG_TRIG_THR, 15'd255);
    write_reg(2'd3, 15'd12345);
    send_sample(0, 0, 32767, 32767, 255, 255, 1);
    send_sample(1, 0, -32768, -32768, 254, 0, 1);
    send_sample(-32768, 32767, 100, 0, 128, 1, 1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      send_idle = (ph < 2) ? 37 : (ph < 4) ? 49 : 0;
      recv_idle = (ph < 2) ? 49 : (ph < 4) ? 37 : 0;
      case (ph)
        0: begin
          write_reg(REG_LEFT_DZ, 15'd32766);
          write_reg(REG_RIGHT_DZ, 15'd0);
          write_reg(REG_TRIG_THR, 15'd254);
        end
        1: begin
          write_reg(REG_LEFT_DZ, 15'd32767);
          write_reg(REG_RIGHT_DZ, 15'd32766);
          write_reg(REG_TRIG_THR, 15'h7F10);
        end
        2: begin
          write_reg(REG_LEFT_DZ, LEFT_DZ_RESET);
          write_reg(REG_RIGHT_DZ, RIGHT_DZ_RESET);
          write_reg(REG_TRIG_THR, 15'd0);
        end
        default: begin
          write_reg(REG_LEFT_DZ, 15'($urandom_range(32767)));
          write_reg(REG_RIGHT_DZ, 15'($urandom_range(32767)));
          write_reg(REG_TRIG_THR, 15'($urandom_range(255)));
        end
      endcase
      random_samples(200);
    end
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
